FILE: src/dseg_pkg.sv
// ----------------------------------------------------------------------------
// dseg_pkg
// Types, constants and helpers shared by the datagram segmenter modules.
// ----------------------------------------------------------------------------
package dseg_pkg;

  localparam int MAX_DATAGRAM_BYTES_DEF = 4096;
  localparam int MAX_SEGMENTS           = 64;
  localparam int QUEUE_DEPTH            = 4;

  localparam int FRAME_W = 9;
  localparam int IDX_W   = 6;
  localparam int LIM_W   = 16;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;
  localparam logic [FRAME_W-1:0] SEG_DEFAULT = 9'd254;
  localparam logic [FRAME_W-1:0] FRAME_HDR   = 9'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_BUSY      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_PID,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic       is_err;
    status_t    status;
    logic       with_hdr;
    logic       with_pid;
    logic [7:0] hdr;
    logic [7:0] pid;
    logic [7:0] data;
    logic       fend;
    logic       last;
  } seg_cmd_t;

  typedef struct packed {
    logic     valid;
    seg_cmd_t cmd;
  } q_head_t;

  function automatic logic [FRAME_W-1:0] seg_size(input logic [FRAME_W-1:0] mfs);
    return (mfs > FRAME_HDR) ? (mfs - FRAME_HDR) : SEG_DEFAULT;
  endfunction

endpackage

FILE: src/dseg_front.sv
// ----------------------------------------------------------------------------
// dseg_front
// Checks each accepted byte, tracks the running datagram and issues one
// command per byte that produces output.
// ----------------------------------------------------------------------------
module dseg_front #(
  parameter int MAX_DATAGRAM_BYTES = dseg_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [7:0]                   data_byte,
  input  logic                         start_flag,
  input  logic [15:0]                  datagram_length,
  input  logic [7:0]                   dg_pid,
  input  logic [dseg_pkg::FRAME_W-1:0] max_frame_size,
  output logic                         push,
  output dseg_pkg::seg_cmd_t           cmd
);
  import dseg_pkg::*;

  localparam int LEN_W = $clog2(MAX_DATAGRAM_BYTES + 1);

  logic             active_r, active_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0] done_r, done_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [FRAME_W-1:0] fill_r, fill_nxt;
  logic [7:0]       pid_r, pid_nxt;

  logic [FRAME_W-1:0] ss;
  logic [LIM_W-1:0]   seg_limit;
  status_t            st;
  logic               go;
  logic [LEN_W-1:0]   eff_total, eff_done, rem, done_inc;
  logic [IDX_W-1:0]   eff_idx;
  logic [FRAME_W-1:0] eff_fill;
  logic [7:0]         eff_pid;
  logic               hdr_due, last_seg, last, fend;

  always_comb begin
    ss        = seg_size(max_frame_size);
    seg_limit = LIM_W'(LIM_W'(ss) * LIM_W'(MAX_SEGMENTS));

    if (datagram_length == 16'd0) begin
      st = ST_EMPTY;
    end else if (datagram_length > 16'(MAX_DATAGRAM_BYTES)) begin
      st = ST_TOO_LARGE;
    end else if (active_r) begin
      st = ST_BUSY;
    end else if (datagram_length > seg_limit) begin
      st = ST_TOO_MANY;
    end else begin
      st = ST_OK;
    end

    go        = start_flag ? (st == ST_OK) : active_r;
    eff_total = start_flag ? datagram_length[LEN_W-1:0] : total_r;
    eff_done  = start_flag ? '0 : done_r;
    eff_idx   = start_flag ? '0 : idx_r;
    eff_fill  = start_flag ? '0 : fill_r;
    eff_pid   = start_flag ? dg_pid : pid_r;

    rem      = eff_total - eff_done;
    last_seg = LIM_W'(rem) <= LIM_W'(ss);
    hdr_due  = (eff_fill == '0);
    done_inc = eff_done + LEN_W'(1);
    last     = (done_inc == eff_total);
    fend     = last || (({1'b0, eff_fill} + 10'd1) >= {1'b0, ss});

    push = accept && (start_flag || active_r);

    cmd.is_err   = !go;
    cmd.status   = go ? ST_OK : st;
    cmd.with_hdr = hdr_due;
    cmd.with_pid = hdr_due && (eff_idx == '0);
    cmd.hdr      = {(eff_idx == '0), last_seg, eff_idx};
    cmd.pid      = eff_pid;
    cmd.data     = data_byte;
    cmd.fend     = fend;
    cmd.last     = last;

    active_nxt = active_r;
    total_nxt  = total_r;
    done_nxt   = done_r;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    pid_nxt    = pid_r;
    if (accept && go) begin
      active_nxt = !last;
      total_nxt  = eff_total;
      done_nxt   = done_inc;
      idx_nxt    = fend ? (eff_idx + IDX_W'(1)) : eff_idx;
      fill_nxt   = fend ? '0 : (eff_fill + FRAME_W'(1));
      pid_nxt    = eff_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      total_r  <= '0;
      done_r   <= '0;
      idx_r    <= '0;
      fill_r   <= '0;
      pid_r    <= '0;
    end else begin
      active_r <= active_nxt;
      total_r  <= total_nxt;
      done_r   <= done_nxt;
      idx_r    <= idx_nxt;
      fill_r   <= fill_nxt;
      pid_r    <= pid_nxt;
    end
  end

endmodule

FILE: src/dseg_queue.sv
// ----------------------------------------------------------------------------
// dseg_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module dseg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dseg_pkg::seg_cmd_t cmd_in,
  input  logic               pop,
  output logic               full,
  output dseg_pkg::q_head_t  head
);
  import dseg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  seg_cmd_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full       = (count_r == CNT_W'(QUEUE_DEPTH));
    head.valid = (count_r != '0);
    head.cmd   = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head.valid;
    wr_ptr_nxt = do_push ? (wr_ptr_r + PTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? (rd_ptr_r + PTR_W'(1)) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/dseg_back.sv
// ----------------------------------------------------------------------------
// dseg_back
// Expands each queued command into header, PID and data words, or an error
// word, and holds them in the output register.
// ----------------------------------------------------------------------------
module dseg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dseg_pkg::q_head_t head,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_frame_end,
  output logic              out_datagram_end,
  output logic [2:0]        out_status
);
  import dseg_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       fend_r, fend_nxt;
  logic       dend_r, dend_nxt;
  status_t    status_r, status_nxt;
  logic       load;

  always_comb begin
    load          = !out_valid_r || !out_stall;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    fend_nxt      = fend_r;
    dend_nxt      = dend_r;
    status_nxt    = status_r;
    if (load) begin
      out_valid_nxt = head.valid;
      if (head.valid) begin
        status_nxt = ST_OK;
        fend_nxt   = 1'b0;
        dend_nxt   = 1'b0;
        case (phase_r)
          PH_HEAD: begin
            if (head.cmd.is_err) begin
              byte_nxt   = 8'd0;
              status_nxt = head.cmd.status;
              pop        = 1'b1;
            end else if (head.cmd.with_hdr) begin
              byte_nxt  = head.cmd.hdr;
              phase_nxt = head.cmd.with_pid ? PH_PID : PH_DATA;
            end else begin
              byte_nxt = head.cmd.data;
              fend_nxt = head.cmd.fend;
              dend_nxt = head.cmd.last;
              pop      = 1'b1;
            end
          end
          PH_PID: begin
            byte_nxt  = head.cmd.pid;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            byte_nxt  = head.cmd.data;
            fend_nxt  = head.cmd.fend;
            dend_nxt  = head.cmd.last;
            pop       = 1'b1;
            phase_nxt = PH_HEAD;
          end
          default: begin
            phase_nxt = PH_HEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    fend_r   <= fend_nxt;
    dend_r   <= dend_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_frame_end    = fend_r;
  assign out_datagram_end = dend_r;
  assign out_status       = status_r;

endmodule

FILE: src/datagram_segmenter.sv
// ----------------------------------------------------------------------------
// datagram_segmenter
// Cuts a byte stream of datagrams into segment frames with header and PID.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Carries
// in_      input      in_valid / in_stall     data byte, start, length, PID
// out_     output     out_valid / out_stall   out byte, frame end, end, status
// cfg_     input      cfg_valid / cfg_ready   max_frame_size
//
// One output word leaves per cycle from the back end's output register
// while out_stall is low and a command is queued. A segment's first byte is
// preceded by a header word, a datagram's first byte by header and PID words;
// the four-entry command queue lets input run ahead. Input is stalled only
// while the command queue is full. Reset is synchronous, with no clearing pass.
// ----------------------------------------------------------------------------
module datagram_segmenter #(
  parameter int MAX_DATAGRAM_BYTES = dseg_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_start_flag,
  input  logic [15:0]                  in_datagram_length,
  input  logic [7:0]                   in_dg_pid,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_frame_end,
  output logic                         out_datagram_end,
  output logic [2:0]                   out_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dseg_pkg::FRAME_W-1:0] cfg_data
);
  import dseg_pkg::*;

  logic [FRAME_W-1:0] max_frame_size_r, max_frame_size_nxt;
  logic               accept;
  logic               push;
  logic               pop;
  logic               q_full;
  seg_cmd_t           cmd;
  q_head_t            head;

  assign cfg_ready          = 1'b1;
  assign max_frame_size_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_frame_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_size_r <= FRAME_RESET;
    end else begin
      max_frame_size_r <= max_frame_size_nxt;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  dseg_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .start_flag      (in_start_flag),
    .datagram_length (in_datagram_length),
    .dg_pid          (in_dg_pid),
    .max_frame_size  (max_frame_size_r),
    .push            (push),
    .cmd             (cmd)
  );

  dseg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .full   (q_full),
    .head   (head)
  );

  dseg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_frame_end    (out_frame_end),
    .out_datagram_end (out_datagram_end),
    .out_status       (out_status)
  );

endmodule

FILE: src/dseg_checker.sv
// ----------------------------------------------------------------------------
// dseg_checker
// Port-level checks on the segmenter's result channel.
// ----------------------------------------------------------------------------
module dseg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_frame_end,
  input logic       out_datagram_end,
  input logic [2:0] out_status
);
  import dseg_pkg::*;

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  a_hold_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_status))
    else $error("stalled result word changed");

  a_error_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_byte == 8'd0) && !out_frame_end && !out_datagram_end)
    else $error("error word carries data");

  a_end_frame : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_datagram_end |-> out_frame_end)
    else $error("datagram ends inside a frame");

endmodule

bind datagram_segmenter dseg_checker u_dseg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte         (out_byte),
  .out_frame_end    (out_frame_end),
  .out_datagram_end (out_datagram_end),
  .out_status       (out_status)
);
